>>> src/template_vector_distance_top_macros.svh
// assertion helpers shared by tvd_queue and tvd_back
`ifndef TEMPLATE_VECTOR_DISTANCE_TOP_MACROS_SVH
`define TEMPLATE_VECTOR_DISTANCE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define TVD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvd assertion failed");

// next-cycle implication, disabled in reset
`define TVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvd assertion failed");

`endif

>>> src/tvd_pkg.sv
`timescale 1ns / 1ps

package tvd_pkg;

    localparam int DataW      = 16;
    localparam int SqW        = 2 * DataW;
    localparam int SumW       = 56;
    localparam int CountW     = 13;
    localparam int FracShift  = 24;
    localparam int ThreshPadW = SumW + 1 - CountW - FracShift;
    localparam int DivSteps   = SumW;
    localparam int DivCntW    = $clog2(DivSteps);
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [CountW-1:0] MAX_ELEMENTS = CountW'(4096);
    localparam logic [SumW-1:0]   SUM_MAX      = {SumW{1'b1}};

    typedef enum logic [1:0] {
        METRIC_L1     = 2'd0,
        METRIC_L2     = 2'd1,
        METRIC_THRESH = 2'd2,
        METRIC_MAHAL  = 2'd3
    } metric_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_DIVIDE,
        B_ACC,
        B_CHECK
    } back_state_t;

    typedef struct packed {
        logic [DataW-1:0]  ad;
        logic [DataW-1:0]  deviation;
        metric_t           mode;
        logic              last;
        logic [CountW-1:0] count;
    } tvd_entry_t;

    typedef struct packed {
        logic       valid;
        tvd_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic       valid;
        tvd_entry_t entry;
    } q_head_t;

endpackage

>>> src/tvd_if.sv
`timescale 1ns / 1ps

interface tvd_in_if;
    logic                       valid;
    logic                       ready;
    logic signed [15:0]         element_a;
    logic signed [15:0]         element_b;
    logic [15:0]                deviation;
    logic                       last_element;

    modport source (output valid, element_a, element_b, deviation, last_element,
                    input ready);
    modport sink   (input valid, element_a, element_b, deviation, last_element,
                    output ready);
endinterface

interface tvd_out_if;
    logic        valid;
    logic        ready;
    logic [55:0] distance_sum;
    logic        within_threshold;
    logic        saturated;

    modport source (output valid, distance_sum, within_threshold, saturated,
                    input ready);
    modport sink   (input valid, distance_sum, within_threshold, saturated,
                    output ready);
endinterface

>>> src/tvd_front.sv
`timescale 1ns / 1ps

module tvd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              metric_we,
    input  logic [1:0]        metric_wdata,
    tvd_in_if.sink            elements,
    input  logic              full,
    output tvd_pkg::q_push_t  push
);

    tvd_pkg::metric_t                 metric_reg;
    logic [tvd_pkg::CountW-1:0]       count_reg;
    logic [tvd_pkg::CountW-1:0]       count_next;
    logic [tvd_pkg::CountW-1:0]       count_inc;
    logic signed [tvd_pkg::DataW:0]   diff;
    logic [tvd_pkg::DataW:0]          abs_diff;
    logic                             accept;
    logic                             vec_end;

    assign elements.ready = !full;
    assign accept         = elements.valid && !full;

    always_comb
    begin
        diff     = {elements.element_a[tvd_pkg::DataW-1], elements.element_a}
                 - {elements.element_b[tvd_pkg::DataW-1], elements.element_b};
        abs_diff = diff[tvd_pkg::DataW] ? (tvd_pkg::DataW+1)'(-diff)
                                        : (tvd_pkg::DataW+1)'(diff);
        count_inc = count_reg + tvd_pkg::CountW'(1);
        // a full-length vector ends on its own
        vec_end   = elements.last_element || (count_inc == tvd_pkg::MAX_ELEMENTS);
        count_next = count_reg;
        if (accept)
        begin
            count_next = vec_end ? '0 : count_inc;
        end
    end

    always_comb
    begin
        push.valid           = accept;
        push.entry.ad        = abs_diff[tvd_pkg::DataW-1:0];
        push.entry.deviation = elements.deviation;
        push.entry.mode      = metric_reg;
        push.entry.last      = vec_end;
        push.entry.count     = count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= tvd_pkg::METRIC_L1;
            count_reg  <= '0;
        end
        else
        begin
            if (metric_we)
            begin
                metric_reg <= tvd_pkg::metric_t'(metric_wdata);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> src/tvd_queue.sv
`timescale 1ns / 1ps

`include "template_vector_distance_top_macros.svh"

module tvd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tvd_pkg::q_push_t  push,
    output logic              full,
    input  logic              pop,
    output tvd_pkg::q_head_t  head
);

    tvd_pkg::tvd_entry_t             mem_reg [tvd_pkg::QueueDepth];
    logic [tvd_pkg::QueuePtrW-1:0]   wr_ptr_reg;
    logic [tvd_pkg::QueuePtrW-1:0]   wr_ptr_next;
    logic [tvd_pkg::QueuePtrW-1:0]   rd_ptr_reg;
    logic [tvd_pkg::QueuePtrW-1:0]   rd_ptr_next;
    logic [tvd_pkg::QueueCntW-1:0]   count_reg;
    logic [tvd_pkg::QueueCntW-1:0]   count_next;

    assign full       = (count_reg == tvd_pkg::QueueCntW'(tvd_pkg::QueueDepth));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + tvd_pkg::QueuePtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + tvd_pkg::QueuePtrW'(1);
        end
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + tvd_pkg::QueueCntW'(1);
            2'b01:   count_next = count_reg - tvd_pkg::QueueCntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `TVD_ASSERT_IMPLY(a_push_room, push.valid, count_reg < tvd_pkg::QueueCntW'(tvd_pkg::QueueDepth))
    `TVD_ASSERT_IMPLY(a_pop_data, pop, count_reg != '0)
    `TVD_ASSERT_NEXT(a_count_step, push.valid && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> src/tvd_back.sv
`timescale 1ns / 1ps

`include "template_vector_distance_top_macros.svh"

module tvd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tvd_pkg::q_head_t  head,
    output logic              pop,
    tvd_out_if.source         results
);

    tvd_pkg::back_state_t            state_reg;
    tvd_pkg::back_state_t            state_next;
    tvd_pkg::tvd_entry_t             work_reg;
    logic [tvd_pkg::SqW-1:0]         sq_reg;
    logic [tvd_pkg::SqW-1:0]         dsq_reg;
    logic [tvd_pkg::SumW-1:0]        num_reg;
    logic [tvd_pkg::SqW-1:0]         rem_reg;
    logic [tvd_pkg::DivCntW-1:0]     div_cnt_reg;
    logic [tvd_pkg::SumW-1:0]        acc_reg;
    logic                            ovf_reg;
    logic                            out_valid_reg;
    logic [tvd_pkg::SumW-1:0]        out_sum_reg;
    logic                            out_close_reg;
    logic                            out_sat_reg;

    logic                            out_free;
    logic                            out_load;
    logic                            dev_zero;
    logic [tvd_pkg::SqW:0]           rem_shift;
    logic [tvd_pkg::SqW:0]           rem_sub;
    logic                            rem_ge;
    logic [tvd_pkg::SumW-1:0]        term;
    logic                            term_sat;
    logic [tvd_pkg::SumW:0]          sum_wide;
    logic                            close;

    assign out_free = !out_valid_reg || results.ready;
    assign dev_zero = (work_reg.deviation == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tvd_pkg::B_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = tvd_pkg::B_SQUARE;
                end
            end
            tvd_pkg::B_SQUARE:
            begin
                if (work_reg.mode == tvd_pkg::METRIC_MAHAL && !dev_zero)
                begin
                    state_next = tvd_pkg::B_DIVIDE;
                end
                else
                begin
                    state_next = tvd_pkg::B_ACC;
                end
            end
            tvd_pkg::B_DIVIDE:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = tvd_pkg::B_ACC;
                end
            end
            tvd_pkg::B_ACC:
            begin
                state_next = work_reg.last ? tvd_pkg::B_CHECK : tvd_pkg::B_IDLE;
            end
            tvd_pkg::B_CHECK:
            begin
                if (out_free)
                begin
                    state_next = tvd_pkg::B_IDLE;
                end
            end
            default: state_next = tvd_pkg::B_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            tvd_pkg::B_IDLE:  pop      = head.valid;
            tvd_pkg::B_CHECK: out_load = out_free;
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // one restoring divide step per cycle
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[tvd_pkg::SumW-1]};
        rem_sub   = rem_shift - {1'b0, dsq_reg};
        rem_ge    = (rem_shift >= {1'b0, dsq_reg});
    end

    always_comb
    begin
        term_sat = 1'b0;
        case (work_reg.mode)
            tvd_pkg::METRIC_L1:
                term = {{(tvd_pkg::SumW-tvd_pkg::DataW){1'b0}}, work_reg.ad};
            tvd_pkg::METRIC_L2, tvd_pkg::METRIC_THRESH:
                term = {{(tvd_pkg::SumW-tvd_pkg::SqW){1'b0}}, sq_reg};
            tvd_pkg::METRIC_MAHAL:
            begin
                term     = dev_zero ? tvd_pkg::SUM_MAX : num_reg;
                term_sat = dev_zero;
            end
            default:
                term = '0;
        endcase
        sum_wide = {1'b0, acc_reg} + {1'b0, term};
        // 2*sum <= count in q.24 units
        close = (work_reg.mode == tvd_pkg::METRIC_THRESH)
             && ({acc_reg, 1'b0} <= {{tvd_pkg::ThreshPadW{1'b0}}, work_reg.count,
                                     {tvd_pkg::FracShift{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvd_pkg::B_IDLE;
            div_cnt_reg   <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tvd_pkg::B_SQUARE)
            begin
                div_cnt_reg <= tvd_pkg::DivCntW'(tvd_pkg::DivSteps - 1);
            end
            else if (state_reg == tvd_pkg::B_DIVIDE)
            begin
                div_cnt_reg <= div_cnt_reg - tvd_pkg::DivCntW'(1);
            end
            if (state_reg == tvd_pkg::B_ACC)
            begin
                acc_reg <= sum_wide[tvd_pkg::SumW] ? tvd_pkg::SUM_MAX
                                                   : sum_wide[tvd_pkg::SumW-1:0];
                ovf_reg <= ovf_reg || term_sat || sum_wide[tvd_pkg::SumW];
            end
            else if (out_load)
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head.entry;
        end
        if (state_reg == tvd_pkg::B_SQUARE)
        begin
            sq_reg  <= tvd_pkg::SqW'(work_reg.ad) * tvd_pkg::SqW'(work_reg.ad);
            dsq_reg <= tvd_pkg::SqW'(work_reg.deviation) * tvd_pkg::SqW'(work_reg.deviation);
            num_reg <= {tvd_pkg::SqW'(work_reg.ad) * tvd_pkg::SqW'(work_reg.ad),
                        {tvd_pkg::FracShift{1'b0}}};
            rem_reg <= '0;
        end
        else if (state_reg == tvd_pkg::B_DIVIDE)
        begin
            num_reg <= {num_reg[tvd_pkg::SumW-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[tvd_pkg::SqW-1:0] : rem_shift[tvd_pkg::SqW-1:0];
        end
        if (out_load)
        begin
            out_sum_reg   <= acc_reg;
            out_close_reg <= close;
            out_sat_reg   <= ovf_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.distance_sum     = out_sum_reg;
    assign results.within_threshold = out_close_reg;
    assign results.saturated        = out_sat_reg;

    `TVD_ASSERT_IMPLY(a_div_mode, state_reg == tvd_pkg::B_DIVIDE, work_reg.mode == tvd_pkg::METRIC_MAHAL && dsq_reg != '0)
    `TVD_ASSERT_IMPLY(a_check_last, state_reg == tvd_pkg::B_CHECK, work_reg.last)
    `TVD_ASSERT_NEXT(a_load_clears, out_load, out_valid_reg && acc_reg == '0 && !ovf_reg)

endmodule

>>> src/template_vector_distance_top.sv
// channel     dir  handshake      payload
// elements    in   valid/ready    element_a, element_b, deviation, last_element
// results     out  valid/ready    distance_sum, within_threshold, saturated
// metric      in   metric_we      metric_wdata (2 bits)
//
// the front takes one element per cycle while the 4-entry queue has room
// back end: each element passes B_IDLE, B_SQUARE and B_ACC; in mode 3 with a nonzero
// deviation it also passes B_DIVIDE (56-step divider) between B_SQUARE and B_ACC,
// plus B_CHECK on the last element of a vector to load the output register
// reset is asynchronous and clears metric, counters, queue and accumulator
// a result waits in the output register; a second result stalls the back end,
// then the queue fills and elements.ready drops
`timescale 1ns / 1ps

module template_vector_distance_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        metric_we,
    input  logic [1:0]  metric_wdata,
    tvd_in_if.sink      elements,
    tvd_out_if.source   results
);

    tvd_pkg::q_push_t push;
    tvd_pkg::q_head_t head;
    logic             full;
    logic             pop;

    tvd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .metric_we    (metric_we),
        .metric_wdata (metric_wdata),
        .elements     (elements),
        .full         (full),
        .push         (push)
    );

    tvd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    tvd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule
